// ===== hw/rtl/wav_header_parser_core_defines.svh =====
// Assertion macros shared by the WAV header parser RTL.
// Each macro expands to one labeled concurrent assertion on clk with rst_n.
`ifndef WAV_HEADER_PARSER_CORE_DEFINES_SVH
`define WAV_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define WAVHP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define WAVHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/wavhp_pkg.sv =====
// Package for the WAV header parser: payload structs, status codes, tags,
// header byte positions and the sequencer state type. No dependencies.
package wavhp_pkg;

  // Field widths.
  localparam int unsigned FRAME_W = 29;  // channels (16) times bytes per sample (13)
  localparam int unsigned PROD_W  = 61;  // sample rate (32) times frame size (29)
  localparam int unsigned DIV_W   = 32;  // dividend and quotient width
  localparam int unsigned DVS_W   = 16;  // divisor width (frame size equals block align)
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // Sample width in bits is shifted right by this amount to give bytes per sample.
  localparam int unsigned BYTE_SHIFT = 3;
  localparam logic [31:0] FMT_SIZE_PCM = 32'd16;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNC     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_FMT_SIZE  = 2'd3;

  // Chunk tags as seen in the little-endian shift register.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Header byte positions at which a field or tag is complete.
  localparam logic [5:0] IDX_RIFF     = 6'd3;
  localparam logic [5:0] IDX_WAVE     = 6'd11;
  localparam logic [5:0] IDX_FMT      = 6'd15;
  localparam logic [5:0] IDX_FMT_SIZE = 6'd19;
  localparam logic [5:0] IDX_FORMAT   = 6'd21;
  localparam logic [5:0] IDX_CHANNELS = 6'd23;
  localparam logic [5:0] IDX_RATE     = 6'd27;
  localparam logic [5:0] IDX_BYTERATE = 6'd31;
  localparam logic [5:0] IDX_ALIGN    = 6'd33;
  localparam logic [5:0] IDX_BITS     = 6'd35;
  localparam logic [5:0] IDX_DATA     = 6'd39;
  localparam logic [5:0] IDX_LAST     = 6'd43;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       start_flag;
    logic       end_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        format_id;
    logic [15:0]        chan_cnt;
    logic [31:0]        rate_hz;
    logic [31:0]        bytes_per_sec;
    logic [15:0]        frame_bytes;
    logic [15:0]        sample_width;
    logic signed [31:0] sample_cnt;
  } out_item_t;

  // Divider request and response.
  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_PARSE = 5'b00001,
    S_FRAME = 5'b00010,
    S_PROD  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DIV   = 5'b10000
  } seq_state_t;

endpackage

// ===== hw/rtl/wav_header_parser_core.sv =====
// WAV header parser top level: byte parser, sequencer for the final checks
// and output register. Depends on wavhp_pkg, wavhp_div and the defines header.
//
// Usage: bytes of a canonical 44-byte RIFF/WAVE header enter on the in_
// channel (in_valid, in_stall, in_data), one per transaction, in file order.
// A byte with start_flag set restarts the parse; bytes outside a parse are
// taken and dropped. Exactly one result transaction leaves on the out_
// channel per header: at the first bad tag or fmt size, at an end_flag
// before byte 43, or after byte 43 once the rate checks and sample count
// are done. Header bytes are taken one per cycle while in_stall is low.
// After byte 43 the block holds in_stall high for the frame size multiply,
// the byte rate multiply, the compares, the bit-serial divider and the
// hand-over of the quotient. When a rate, alignment or zero frame check
// fails the stall ends after the compare. Results appear in the cycle after
// the deciding byte, or at the end of that sequence. The result sits in an
// output register; while it is stalled, in_stall is also raised so that no
// second result can be produced. Synchronous reset leaves the block idle,
// waiting for a start byte, with no result pending.
`include "wav_header_parser_core_defines.svh"
module wav_header_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wavhp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wavhp_pkg::out_item_t out_data
);

  // Sequencer and parse state.
  wavhp_pkg::seq_state_t state_r, state_nxt;
  logic        finished_r;
  logic [5:0]  idx_r;
  logic [31:0] tag_r;
  logic [15:0] format_r;
  logic [15:0] channels_r;
  logic [31:0] rate_r;
  logic [31:0] byterate_r;
  logic [15:0] align_r;
  logic [15:0] bits_r;
  logic [31:0] fmtsize_r;
  logic [31:0] datasize_r;

  // Final check datapath.
  logic [wavhp_pkg::FRAME_W-1:0] frame_r;
  logic [wavhp_pkg::PROD_W-1:0]  prod_r;
  logic                          neg_r;

  // Output register.
  logic                 out_valid_r;
  wavhp_pkg::out_item_t out_data_r;

  // Byte parse next values.
  logic        in_acc;
  logic        fin_cur;
  logic [5:0]  idx_cur;
  logic [31:0] tag_nxt;
  logic [15:0] format_nxt;
  logic [15:0] channels_nxt;
  logic [31:0] rate_nxt;
  logic [31:0] byterate_nxt;
  logic [15:0] align_nxt;
  logic [15:0] bits_nxt;
  logic [31:0] fmtsize_nxt;
  logic [31:0] datasize_nxt;
  logic        bad;
  logic [1:0]  bad_code;
  logic        emit_parse;
  logic [1:0]  parse_status;
  logic        go_finish;

  // Check and divide.
  logic                 check_fail;
  wavhp_pkg::div_req_t  div_req;
  wavhp_pkg::div_rsp_t  div_rsp;
  logic [31:0]          samples;
  logic                 out_load;
  wavhp_pkg::out_item_t out_load_data;

  assign in_acc = in_valid && !in_stall;

  // Decode one header byte; a start byte sees cleared fields.
  always_comb begin
    logic [31:0] tag_cur;
    tag_cur      = in_data.start_flag ? '0 : tag_r;
    fin_cur      = in_data.start_flag ? 1'b0 : finished_r;
    idx_cur      = in_data.start_flag ? '0 : idx_r;
    format_nxt   = in_data.start_flag ? '0 : format_r;
    channels_nxt = in_data.start_flag ? '0 : channels_r;
    rate_nxt     = in_data.start_flag ? '0 : rate_r;
    byterate_nxt = in_data.start_flag ? '0 : byterate_r;
    align_nxt    = in_data.start_flag ? '0 : align_r;
    bits_nxt     = in_data.start_flag ? '0 : bits_r;
    fmtsize_nxt  = in_data.start_flag ? '0 : fmtsize_r;
    datasize_nxt = in_data.start_flag ? '0 : datasize_r;
    tag_nxt      = {in_data.header_byte, tag_cur[31:8]};
    bad          = 1'b0;
    bad_code     = wavhp_pkg::ST_MALFORMED;
    unique case (idx_cur)
      wavhp_pkg::IDX_RIFF:     bad = (tag_nxt != wavhp_pkg::TAG_RIFF);
      wavhp_pkg::IDX_WAVE:     bad = (tag_nxt != wavhp_pkg::TAG_WAVE);
      wavhp_pkg::IDX_FMT:      bad = (tag_nxt != wavhp_pkg::TAG_FMT);
      wavhp_pkg::IDX_FMT_SIZE: fmtsize_nxt = tag_nxt;
      wavhp_pkg::IDX_FORMAT:   format_nxt = tag_nxt[31:16];
      wavhp_pkg::IDX_CHANNELS: channels_nxt = tag_nxt[31:16];
      wavhp_pkg::IDX_RATE:     rate_nxt = tag_nxt;
      wavhp_pkg::IDX_BYTERATE: byterate_nxt = tag_nxt;
      wavhp_pkg::IDX_ALIGN:    align_nxt = tag_nxt[31:16];
      wavhp_pkg::IDX_BITS: begin
        bits_nxt = tag_nxt[31:16];
        if (fmtsize_nxt != wavhp_pkg::FMT_SIZE_PCM) begin
          bad      = 1'b1;
          bad_code = wavhp_pkg::ST_FMT_SIZE;
        end
      end
      wavhp_pkg::IDX_DATA:     bad = (tag_nxt != wavhp_pkg::TAG_DATA);
      wavhp_pkg::IDX_LAST:     datasize_nxt = tag_nxt;
      default: ;
    endcase
    // A tag or size error wins over the end of the stream.
    go_finish    = !fin_cur && !bad && (idx_cur >= wavhp_pkg::IDX_LAST);
    emit_parse   = !fin_cur && (bad || (!go_finish && in_data.end_flag));
    parse_status = bad ? bad_code : wavhp_pkg::ST_TRUNC;
  end

  // Parse registers advance on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r <= 1'b1;
      idx_r      <= '0;
    end else if (in_acc) begin
      finished_r <= fin_cur || emit_parse || go_finish;
      idx_r      <= idx_cur + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_r      <= tag_nxt;
      format_r   <= format_nxt;
      channels_r <= channels_nxt;
      rate_r     <= rate_nxt;
      byterate_r <= byterate_nxt;
      align_r    <= align_nxt;
      bits_r     <= bits_nxt;
      fmtsize_r  <= fmtsize_nxt;
      datasize_r <= datasize_nxt;
    end
  end

  // Sequencer for the checks after the last header byte.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wavhp_pkg::S_PARSE: if (in_acc && go_finish) state_nxt = wavhp_pkg::S_FRAME;
      wavhp_pkg::S_FRAME: state_nxt = wavhp_pkg::S_PROD;
      wavhp_pkg::S_PROD:  state_nxt = wavhp_pkg::S_CHECK;
      wavhp_pkg::S_CHECK: state_nxt = check_fail ? wavhp_pkg::S_PARSE : wavhp_pkg::S_DIV;
      wavhp_pkg::S_DIV:   if (div_rsp.done) state_nxt = wavhp_pkg::S_PARSE;
      default:            state_nxt = wavhp_pkg::S_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wavhp_pkg::S_PARSE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame size, then byte rate product, each registered.
  always_ff @(posedge clk) begin
    if (state_r == wavhp_pkg::S_FRAME) begin
      frame_r <= {{(wavhp_pkg::FRAME_W-16){1'b0}}, channels_r}
               * {{(wavhp_pkg::FRAME_W-16+wavhp_pkg::BYTE_SHIFT){1'b0}},
                  bits_r[15:wavhp_pkg::BYTE_SHIFT]};
    end
    if (state_r == wavhp_pkg::S_PROD) begin
      prod_r <= {{(wavhp_pkg::PROD_W-32){1'b0}}, rate_r}
              * {{(wavhp_pkg::PROD_W-wavhp_pkg::FRAME_W){1'b0}}, frame_r};
    end
    if (state_r == wavhp_pkg::S_CHECK) begin
      neg_r <= datasize_r[31];
    end
  end

  // Byte rate, block align and zero frame checks.
  assign check_fail = (prod_r != {{(wavhp_pkg::PROD_W-32){1'b0}}, byterate_r})
                   || (frame_r != {{(wavhp_pkg::FRAME_W-16){1'b0}}, align_r})
                   || (frame_r == '0);

  // The divider works on the magnitude of the data size.
  assign div_req.go       = (state_r == wavhp_pkg::S_CHECK) && !check_fail;
  assign div_req.dividend = datasize_r[31] ? (~datasize_r + 32'd1) : datasize_r;
  assign div_req.divisor  = align_r;

  wavhp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign samples = neg_r ? (~div_rsp.quotient + 32'd1) : div_rsp.quotient;

  // Select the result transaction to load.
  always_comb begin
    out_load      = 1'b0;
    out_load_data = '0;
    priority if (in_acc && emit_parse) begin
      out_load                    = 1'b1;
      out_load_data.status        = parse_status;
      out_load_data.format_id     = format_nxt;
      out_load_data.chan_cnt      = channels_nxt;
      out_load_data.rate_hz       = rate_nxt;
      out_load_data.bytes_per_sec = byterate_nxt;
      out_load_data.frame_bytes   = align_nxt;
      out_load_data.sample_width  = bits_nxt;
    end else if (((state_r == wavhp_pkg::S_CHECK) && check_fail)
                 || ((state_r == wavhp_pkg::S_DIV) && div_rsp.done)) begin
      out_load                    = 1'b1;
      out_load_data.status        = (state_r == wavhp_pkg::S_DIV) ?
                                    wavhp_pkg::ST_OK : wavhp_pkg::ST_MALFORMED;
      out_load_data.format_id     = format_r;
      out_load_data.chan_cnt      = channels_r;
      out_load_data.rate_hz       = rate_r;
      out_load_data.bytes_per_sec = byterate_r;
      out_load_data.frame_bytes   = align_r;
      out_load_data.sample_width  = bits_r;
      out_load_data.sample_cnt    = (state_r == wavhp_pkg::S_DIV) ? samples : '0;
    end else begin
      out_load = 1'b0;
    end
  end

  // Output register holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

  assign in_stall  = (state_r != wavhp_pkg::S_PARSE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result never overwrites one that the receiver has not taken.
  `WAVHP_ASSERT_IMPL(a_no_overwrite, out_load, !(out_valid_r && out_stall), "result overwritten")
  // Divider completion only occurs while the sequencer waits for it.
  `WAVHP_ASSERT_IMPL(a_div_in_state, div_rsp.done, state_r == wavhp_pkg::S_DIV, "stray divide done")
  // Starting the final checks always goes on to the product stage.
  `WAVHP_ASSERT_NEXT(a_frame_then_prod, state_r == wavhp_pkg::S_FRAME,
                     state_r == wavhp_pkg::S_PROD, "sequencer skipped product stage")

endmodule

// ===== hw/rtl/wavhp_div.sv =====
// Iterative restoring divider for the WAV header parser, one quotient bit
// per cycle through a single shared subtractor. Depends on wavhp_pkg.
module wavhp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  wavhp_pkg::div_req_t req,
  output wavhp_pkg::div_rsp_t rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [wavhp_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [wavhp_pkg::DVS_W-1:0]       rem_r;
  logic [wavhp_pkg::DVS_W-1:0]       dvs_r;
  logic [wavhp_pkg::DIV_W-1:0]       dq_r;
  logic [wavhp_pkg::DVS_W:0]         shifted;
  logic [wavhp_pkg::DVS_W:0]         diff;
  logic                              fits;
  logic [wavhp_pkg::DVS_W-1:0]       rem_nxt;

  // One step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    shifted = {rem_r, dq_r[wavhp_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[wavhp_pkg::DVS_W-1:0] : shifted[wavhp_pkg::DVS_W-1:0];
  end

  // Control: a run takes one step per quotient bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - {{(wavhp_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
      end
    end
  end

  // Datapath: the quotient bits replace the dividend bits from the bottom.
  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      dq_r  <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[wavhp_pkg::DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

// ===== sim/wav_header_checker.sv =====
// Checker for the WAV header parser: watches both channels, predicts each header's
// report from the accepted bytes and compares it with the result transactions.
// Depends on wavhp_pkg for the payload structs, status codes, tags and byte positions.
module wav_header_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  wavhp_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  wavhp_pkg::out_item_t out_data,
  output int unsigned          mismatches,
  output int unsigned          waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parse state of the predictor.
  logic [5:0]  hdr_pos;
  logic        parse_idle;
  logic [31:0] shift_word;
  logic [15:0] fmt_code;
  logic [15:0] chan_count;
  logic [31:0] rate_field;
  logic [31:0] brate_field;
  logic [15:0] align_field;
  logic [15:0] bits_field;
  logic [31:0] fmt_len;
  logic [31:0] data_len;

  // Reports predicted but not yet seen on the result channel, oldest first.
  wavhp_pkg::out_item_t pending_reports[$];

  function automatic void clear_capture();
    hdr_pos     = '0;
    shift_word  = '0;
    fmt_code    = '0;
    chan_count  = '0;
    rate_field  = '0;
    brate_field = '0;
    align_field = '0;
    bits_field  = '0;
    fmt_len     = '0;
    data_len    = '0;
  endfunction

  // Any report ends the parse until the next start byte.
  function automatic wavhp_pkg::out_item_t header_report(input logic [1:0] status,
                                                         input logic [31:0] samples);
    wavhp_pkg::out_item_t rep;
    rep.status        = status;
    rep.format_id     = fmt_code;
    rep.chan_cnt      = chan_count;
    rep.rate_hz       = rate_field;
    rep.bytes_per_sec = brate_field;
    rep.frame_bytes   = align_field;
    rep.sample_width  = bits_field;
    rep.sample_cnt    = samples;
    parse_idle = 1'b1;
    return rep;
  endfunction

  // End of header: rate and alignment checks, then the signed sample count.
  // The product is kept at 64 bits so that an overflow can never match.
  function automatic wavhp_pkg::out_item_t final_report();
    logic [63:0] frame;
    logic [63:0] product;
    longint      dividend;
    longint      divisor;
    longint      quotient;
    frame   = 64'(chan_count) * 64'(bits_field >> wavhp_pkg::BYTE_SHIFT);
    product = 64'(rate_field) * frame;
    if (product != 64'(brate_field) || frame != 64'(align_field) || frame == '0) begin
      return header_report(wavhp_pkg::ST_MALFORMED, '0);
    end
    dividend = longint'($signed(data_len));
    divisor  = longint'(frame);
    quotient = dividend / divisor;
    return header_report(wavhp_pkg::ST_OK, quotient[31:0]);
  endfunction

  // Takes one accepted byte; returns 1 when it produces a report.
  function automatic bit take_header_byte(input wavhp_pkg::in_item_t it,
                                          output wavhp_pkg::out_item_t rep);
    logic       bad;
    logic [1:0] code;
    bad  = 1'b0;
    code = wavhp_pkg::ST_MALFORMED;
    if (it.start_flag) begin
      clear_capture();
      parse_idle = 1'b0;
    end
    if (parse_idle) begin
      return 1'b0;
    end
    shift_word = {it.header_byte, shift_word[31:8]};
    case (hdr_pos)
      wavhp_pkg::IDX_RIFF:     bad = (shift_word != wavhp_pkg::TAG_RIFF);
      wavhp_pkg::IDX_WAVE:     bad = (shift_word != wavhp_pkg::TAG_WAVE);
      wavhp_pkg::IDX_FMT:      bad = (shift_word != wavhp_pkg::TAG_FMT);
      wavhp_pkg::IDX_FMT_SIZE: fmt_len = shift_word;
      wavhp_pkg::IDX_FORMAT:   fmt_code = shift_word[31:16];
      wavhp_pkg::IDX_CHANNELS: chan_count = shift_word[31:16];
      wavhp_pkg::IDX_RATE:     rate_field = shift_word;
      wavhp_pkg::IDX_BYTERATE: brate_field = shift_word;
      wavhp_pkg::IDX_ALIGN:    align_field = shift_word[31:16];
      wavhp_pkg::IDX_BITS: begin
        bits_field = shift_word[31:16];
        if (fmt_len != wavhp_pkg::FMT_SIZE_PCM) begin
          bad  = 1'b1;
          code = wavhp_pkg::ST_FMT_SIZE;
        end
      end
      wavhp_pkg::IDX_DATA:     bad = (shift_word != wavhp_pkg::TAG_DATA);
      wavhp_pkg::IDX_LAST:     data_len = shift_word;
      default: ;
    endcase
    // An error wins over an end of stream on the same byte.
    if (bad) begin
      rep = header_report(code, '0);
    end else if (hdr_pos >= wavhp_pkg::IDX_LAST) begin
      rep = final_report();
    end else if (it.end_flag) begin
      rep = header_report(wavhp_pkg::ST_TRUNC, '0);
    end else begin
      hdr_pos = hdr_pos + 6'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
    end
  endtask

  // Results are checked before the byte of the same edge is predicted; a byte
  // can never produce a result on the edge at which it is taken.
  always @(posedge clk) begin
    wavhp_pkg::out_item_t want;
    wavhp_pkg::out_item_t rep;
    if (!rst_n) begin
      clear_capture();
      parse_idle = 1'b1;
      pending_reports.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result transaction with no report predicted, status %0d",
                     $realtime, out_data.status);
          end
        end else begin
          want = pending_reports.pop_front();
          compare_field("status",        32'(want.status),       32'(out_data.status));
          compare_field("format_id",     32'(want.format_id),    32'(out_data.format_id));
          compare_field("chan_cnt",      32'(want.chan_cnt),     32'(out_data.chan_cnt));
          compare_field("rate_hz",       want.rate_hz,           out_data.rate_hz);
          compare_field("bytes_per_sec", want.bytes_per_sec,     out_data.bytes_per_sec);
          compare_field("frame_bytes",   32'(want.frame_bytes),  32'(out_data.frame_bytes));
          compare_field("sample_width",  32'(want.sample_width),
                        32'(out_data.sample_width));
          compare_field("sample_cnt",    want.sample_cnt,        out_data.sample_cnt);
        end
      end
      if (in_valid && !in_stall) begin
        if (take_header_byte(in_data, rep)) begin
          pending_reports.push_back(rep);
        end
      end
    end
    waiting = pending_reports.size();
  end

endmodule

// ===== sim/tb.sv =====
// Top of the WAV header parser testbench: clock, reset, byte stimulus and the
// result-side stall pattern. Depends on wavhp_pkg, wav_header_parser_core and
// wav_header_checker, which does all prediction and comparison.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  wavhp_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  wavhp_pkg::out_item_t out_data;
  int unsigned          mismatches;
  int unsigned          waiting;

  // Stimulus controls.
  logic [7:0]  hdr [44];
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned header_bytes;
  logic        hold_on;
  logic        hold_over;

  wav_header_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  wav_header_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  always @(negedge clk) begin
    out_stall <= (hold_on && !hold_over) || ($urandom_range(99) < stall_pct);
  end

  // Length of the long hold-off, counted in clock cycles.
  initial begin
    hold_over = 1'b0;
    wait (hold_on);
    repeat (400) @(posedge clk);
    hold_over = 1'b1;
  end

  // One input transaction, with random idle cycles before it. Valid stays high
  // on return; the next call either idles or presents the next byte.
  task automatic send_item(input wavhp_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_loose(input logic [7:0] value, input logic last);
    wavhp_pkg::in_item_t it;
    it.header_byte = value;
    it.start_flag  = 1'b0;
    it.end_flag    = last;
    send_item(it);
  endtask

  // Sends the first count bytes of hdr; end_at marks the end of the stream (-1: none).
  task automatic send_header(input int count, input int end_at);
    wavhp_pkg::in_item_t it;
    for (int i = 0; i < count; i++) begin
      it.header_byte = hdr[i];
      it.start_flag  = (i == 0);
      it.end_flag    = (i == end_at);
      send_item(it);
      header_bytes++;
    end
  endtask

  task automatic put_word(input int at, input logic [31:0] value);
    for (int k = 0; k < 4; k++) begin
      hdr[at + k] = value[8*k +: 8];
    end
  endtask

  task automatic put_half(input int at, input logic [15:0] value);
    hdr[at]     = value[7:0];
    hdr[at + 1] = value[15:8];
  endtask

  // Canonical layout; the RIFF size is random since the block ignores it.
  task automatic make_header(input logic [15:0] fmt, input logic [15:0] ch,
                             input logic [31:0] rate, input logic [31:0] brate,
                             input logic [15:0] align, input logic [15:0] bits,
                             input logic [31:0] fsize, input logic [31:0] dsize);
    put_word(0, wavhp_pkg::TAG_RIFF);
    put_word(4, $urandom);
    put_word(8, wavhp_pkg::TAG_WAVE);
    put_word(12, wavhp_pkg::TAG_FMT);
    put_word(16, fsize);
    put_half(20, fmt);
    put_half(22, ch);
    put_word(24, rate);
    put_word(28, brate);
    put_half(32, align);
    put_half(34, bits);
    put_word(36, wavhp_pkg::TAG_DATA);
    put_word(40, dsize);
  endtask

  // Header whose byte rate and block align agree with the format fields.
  task automatic make_pcm(input logic [15:0] fmt, input logic [15:0] ch,
                          input logic [31:0] rate, input logic [15:0] bits,
                          input logic [31:0] dsize);
    logic [31:0] frame;
    frame = 32'(ch) * 32'(bits >> 3);
    make_header(fmt, ch, rate, rate * frame, frame[15:0], bits,
                wavhp_pkg::FMT_SIZE_PCM, dsize);
  endtask

  // Mostly well-formed headers with random content, the rest damaged,
  // cut short or abandoned, sometimes followed by stray bytes.
  task automatic random_header();
    logic [15:0] ch;
    logic [15:0] bits;
    logic [15:0] fmt;
    logic [31:0] rate;
    logic [31:0] dsize;
    logic [31:0] fsize;
    int          kind;
    int          pos;
    int          count;
    int          end_at;
    case ($urandom_range(9))
      0:       ch = 16'($urandom);
      1:       ch = '0;
      default: ch = 16'($urandom_range(1, 8));
    endcase
    case ($urandom_range(9))
      0:       bits = 16'($urandom);
      1:       bits = 16'($urandom_range(0, 7));
      default: bits = 16'(8 * $urandom_range(1, 4));
    endcase
    rate  = ($urandom_range(4) == 0) ? 32'($urandom) : 32'($urandom_range(8000, 192000));
    fmt   = ($urandom_range(3) == 0) ? 16'($urandom) : ($urandom_range(1) ? 16'd1 : 16'd3);
    dsize = $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(0, 100000));
    make_pcm(fmt, ch, rate, bits, dsize);
    count  = 44;
    end_at = -1;
    kind   = $urandom_range(99);
    // Damaged headers sometimes also end the stream, at any header byte.
    if (kind >= 45 && kind < 83 && $urandom_range(2) == 0) begin
      end_at = $urandom_range(0, 43);
    end
    if (kind < 45) begin
      if ($urandom_range(3) == 0) begin
        end_at = 43;
      end
    end else if (kind < 55) begin
      hdr[$urandom_range(28, 31)] ^= 8'(1 << $urandom_range(7));
    end else if (kind < 62) begin
      hdr[$urandom_range(32, 33)] ^= 8'(1 << $urandom_range(7));
    end else if (kind < 68) begin
      // Less than one byte per sample, with rate and align consistent at zero.
      put_half(34, 16'($urandom_range(0, 7)));
      put_word(28, '0);
      put_half(32, '0);
    end else if (kind < 75) begin
      fsize = $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(0, 40));
      if (fsize == wavhp_pkg::FMT_SIZE_PCM) begin
        fsize = 32'd18;
      end
      put_word(16, fsize);
    end else if (kind < 83) begin
      case ($urandom_range(3))
        0:       pos = $urandom_range(0, 3);
        1:       pos = $urandom_range(8, 11);
        2:       pos = $urandom_range(12, 15);
        default: pos = $urandom_range(36, 39);
      endcase
      hdr[pos] ^= 8'($urandom_range(1, 255));
    end else if (kind < 93) begin
      end_at = $urandom_range(0, 43);
    end else begin
      count = $urandom_range(1, 43);
    end
    send_header(count, end_at);
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) send_loose(8'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    int unsigned target;
    int          tag_end[4];
    phase_idle   = '{0, 80, 0, 15};
    phase_stall  = '{0, 0, 80, 15};
    tag_end      = '{3, 11, 15, 39};
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    header_bytes = 0;
    hold_on      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Bytes outside a parse are dropped.
    send_loose(8'h00, 1'b0);
    send_loose(8'hFF, 1'b1);

    // Good headers: common PCM, float with an all-ones (negative) data size,
    // a negative quotient, the largest frame, and a zero rate with a huge sample width.
    make_pcm(16'd1, 16'd2, 32'd44100, 16'd16, 32'd176400);
    send_header(44, -1);
    make_pcm(16'd3, 16'd2, 32'd48000, 16'd32, 32'hFFFF_FFFF);
    send_header(44, 43);
    make_pcm(16'd1, 16'd1, 32'd8000, 16'd24, 32'h8000_0000);
    send_header(44, -1);
    make_pcm(16'hFFFF, 16'hFFFF, 32'd1, 16'd8, 32'h7FFF_FFFF);
    send_header(44, -1);
    make_pcm(16'd1, 16'd1, 32'd0, 16'hFFFF, 32'd0);
    send_header(44, -1);

    // Stream ends on the first byte, and inside the fmt chunk.
    send_header(1, 0);
    send_header(44, 20);

    // A bad tag is judged on its fourth byte, even when that byte ends the stream.
    for (int i = 0; i < 4; i++) begin
      make_pcm(16'd1, 16'd2, 32'd44100, 16'd16, 32'd1000);
      hdr[tag_end[i]] ^= 8'h01;
      send_header(44, (i < 2) ? tag_end[i] : -1);
    end

    // fmt chunk size other than 16, reported on the byte that ends the stream.
    make_header(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16, 32'd18, 32'd100);
    send_header(44, 35);

    // Byte rate off, block align off, zero frame size, product beyond 32 bits.
    make_header(16'd1, 16'd2, 32'd44100, 32'd176401, 16'd4, 16'd16,
                wavhp_pkg::FMT_SIZE_PCM, 32'd100);
    send_header(44, -1);
    make_header(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd5, 16'd16,
                wavhp_pkg::FMT_SIZE_PCM, 32'd100);
    send_header(44, -1);
    make_header(16'd1, 16'd2, 32'd8000, 32'd0, 16'd0, 16'd4,
                wavhp_pkg::FMT_SIZE_PCM, 32'd100);
    send_header(44, -1);
    make_pcm(16'd1, 16'd2, 32'hFFFF_FFFF, 16'd16, 32'd100);
    send_header(44, -1);

    // A start byte in the middle of a header restarts the parse.
    make_pcm(16'd1, 16'd2, 32'd22050, 16'd16, 32'd1000);
    send_header(20, -1);
    send_header(44, -1);

    // Random headers under each idling pattern.
    target = header_bytes;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      target += 300;
      while (header_bytes < target) begin
        random_header();
      end
      // Long receiver hold-off: the held result must back up into the byte input.
      if (ph == 0) begin
        hold_on = 1'b1;
        repeat (4) begin
          make_pcm(16'd1, 16'd2, 32'd48000, 16'd16, $urandom);
          send_header(44, -1);
        end
      end
    end

    // Drain, then give any stray result time to show up.
    in_valid  = 1'b0;
    stall_pct = 0;
    wait (waiting == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
